// ----- design/spr_pkg.sv -----
// Shared types, widths and codes of the stable priority run queue.
package spr_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ID_W                = 8;
   localparam int PRIO_W              = 8;
   localparam int OP_W                = 2;
   localparam int TALLY_W             = 16;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;

   // register index, taken from paddr[2]
   localparam logic REG_DEFAULT_PRIORITY = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_PEEK    = 2'd2
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } status_type;

endpackage

// ----- design/spr_csr.sv -----
// Configuration register block: default priority over the APB-style port.
module spr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [spr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [spr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [spr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [spr_pkg::PRIO_W-1:0]      default_priority
);
   import spr_pkg::*;

   logic [PRIO_W-1:0] default_priority_ff;
   logic [PRIO_W-1:0] default_priority_in;
   logic              wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_DEFAULT_PRIORITY);

   always_comb begin
      default_priority_in = default_priority_ff;
      if (wr_hit) begin
         default_priority_in = pwdata[PRIO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_priority_ff <= '0;
      end else begin
         default_priority_ff <= default_priority_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_DEFAULT_PRIORITY) begin
         prdata = {{(CSR_DATA_W-PRIO_W){1'b0}}, default_priority_ff};
      end
   end

   assign default_priority = default_priority_ff;

endmodule

// ----- design/spr_ctrl.sv -----
// Controller: request/response handshake and the two-state sequencer.
module spr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  spr_pkg::status_type  status,
   output spr_pkg::cmd_type     cmd
);
   import spr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      accept       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = !rsp_valid_ff || rsp_ready;
            accept        = req_valid && req_ready;
            cmd.latch_req = accept;
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // accepted request always runs its execute cycle next
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_req |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execute");

   // execute always leaves a response pending
   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("execute did not raise rsp_valid");

   // no response is pending while executing, so results are never overwritten
   a_exec_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !rsp_valid_ff)
      else $error("response slot busy during execute");

   // status is consistent
   a_status: assert property (@(posedge clock) disable iff (reset)
      !(status.full && status.empty))
      else $error("queue reported full and empty");

endmodule

// ----- design/spr_datapath.sv -----
// Datapath: shift-register sorted slots, per-slot compares, counters and result register.
module spr_datapath #(
   parameter int QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  spr_pkg::cmd_type                     cmd,
   output spr_pkg::status_type                  status,
   input  logic [spr_pkg::OP_W-1:0]             req_operation,
   input  logic [spr_pkg::ID_W-1:0]             req_thread_id,
   input  logic [spr_pkg::PRIO_W-1:0]           req_priority_req,
   input  logic                                 req_has_priority,
   input  logic [spr_pkg::PRIO_W-1:0]           default_priority,
   output logic                                 rsp_head_valid,
   output logic [spr_pkg::ID_W-1:0]             rsp_head_id,
   output logic [spr_pkg::PRIO_W-1:0]           rsp_head_priority,
   output logic                                 rsp_removed,
   output logic                                 rsp_duplicate,
   output logic                                 rsp_overflow,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]     rsp_entry_count,
   output logic [spr_pkg::TALLY_W-1:0]          rsp_duplicate_total
);
   import spr_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LOG_D = $clog2(QUEUE_DEPTH);

   // latched request
   op_type            op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [PRIO_W-1:0] prio_ff;

   // slots, slot 0 is the head
   logic [ID_W-1:0]   slot_id_ff   [QUEUE_DEPTH];
   logic [PRIO_W-1:0] slot_prio_ff [QUEUE_DEPTH];
   logic [ID_W-1:0]   slot_id_in   [QUEUE_DEPTH];
   logic [PRIO_W-1:0] slot_prio_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;

   // result register
   logic               head_valid_ff;
   logic [ID_W-1:0]    head_id_ff;
   logic [PRIO_W-1:0]  head_prio_ff;
   logic               removed_ff, removed_in;
   logic               dup_ff, dup_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   count_rsp_ff;
   logic [TALLY_W-1:0] tally_rsp_ff;

   logic [QUEUE_DEPTH-1:0] occupied, le, match, at_or_after, prev_le;
   logic                   hit, full;

   assign full         = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.full  = full;
   assign status.empty = (count_ff == '0);

   // per-slot compares
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         occupied[i] = (CNT_W'(i) < count_ff);
         le[i]       = occupied[i] && (slot_prio_ff[i] <= prio_ff);
         match[i]    = occupied[i] && (slot_id_ff[i] == id_ff);
      end
   end

   assign hit     = |match;
   assign prev_le = {le[QUEUE_DEPTH-2:0], 1'b1};

   // prefix OR: slots at or after the first match, log-depth doubling
   always_comb begin
      at_or_after = match;
      for (int s = 0; s < LOG_D; s++) begin
         at_or_after = at_or_after | (at_or_after << (1 << s));
      end
   end

   always_comb begin
      slot_id_in   = slot_id_ff;
      slot_prio_in = slot_prio_ff;
      count_in     = count_ff;
      tally_in     = tally_ff;
      removed_in   = 1'b0;
      dup_in       = 1'b0;
      ovf_in       = 1'b0;
      unique case (op_ff)
         OP_ENQUEUE: begin
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               dup_in = hit;
               if (hit && (tally_ff != '1)) begin
                  tally_in = tally_ff + 1'b1;
               end
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (!le[i]) begin
                     if (prev_le[i]) begin
                        slot_id_in[i]   = id_ff;
                        slot_prio_in[i] = prio_ff;
                     end else begin
                        slot_id_in[i]   = slot_id_ff[(i == 0) ? 0 : i-1];
                        slot_prio_in[i] = slot_prio_ff[(i == 0) ? 0 : i-1];
                     end
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               removed_in = 1'b1;
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  if (at_or_after[i]) begin
                     slot_id_in[i]   = slot_id_ff[i+1];
                     slot_prio_in[i] = slot_prio_ff[i+1];
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff   <= op_type'(req_operation);
         id_ff   <= req_thread_id;
         prio_ff <= req_has_priority ? req_priority_req : default_priority;
      end
      if (cmd.execute) begin
         slot_id_ff    <= slot_id_in;
         slot_prio_ff  <= slot_prio_in;
         head_valid_ff <= (count_in != '0);
         head_id_ff    <= (count_in != '0) ? slot_id_in[0] : '0;
         head_prio_ff  <= (count_in != '0) ? slot_prio_in[0] : '0;
         removed_ff    <= removed_in;
         dup_ff        <= dup_in;
         ovf_ff        <= ovf_in;
         count_rsp_ff  <= count_in;
         tally_rsp_ff  <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tally_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
         tally_ff <= tally_in;
      end
   end

   assign rsp_head_valid      = head_valid_ff;
   assign rsp_head_id         = head_id_ff;
   assign rsp_head_priority   = head_prio_ff;
   assign rsp_removed         = removed_ff;
   assign rsp_duplicate       = dup_ff;
   assign rsp_overflow        = ovf_ff;
   assign rsp_entry_count     = count_rsp_ff;
   assign rsp_duplicate_total = tally_rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond depth");

   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && (op_ff == OP_ENQUEUE) && full) |=>
         (rsp_overflow && !rsp_duplicate && (count_ff == $past(count_ff))))
      else $error("full enqueue changed the queue");

   a_remove_dec: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && (op_ff == OP_REMOVE) && hit) |=>
         (rsp_removed && (count_ff == $past(count_ff) - 1'b1)))
      else $error("remove hit did not drop one entry");

endmodule

// ----- design/stable_priority_run_queue.sv -----
// Top level of the stable priority run queue: CSR block, controller and datapath.
// Sequence: a request transfer moves the controller to EXEC, which updates the
//   slots and registers the response; rsp_valid rises after EXEC.
// Flow: the latch/execute sequence of the controller takes no request during
//   EXEC, and a new request is taken only once the previous response transfers.
// Reset: synchronous, active high; clears entry count, duplicate tally, the
//   default priority register and the handshake state. Slots are not cleared.
module stable_priority_run_queue #(
   parameter int QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [spr_pkg::OP_W-1:0]             req_operation,
   input  logic [spr_pkg::ID_W-1:0]             req_thread_id,
   input  logic [spr_pkg::PRIO_W-1:0]           req_priority_req,
   input  logic                                 req_has_priority,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_head_valid,
   output logic [spr_pkg::ID_W-1:0]             rsp_head_id,
   output logic [spr_pkg::PRIO_W-1:0]           rsp_head_priority,
   output logic                                 rsp_removed,
   output logic                                 rsp_duplicate,
   output logic                                 rsp_overflow,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]     rsp_entry_count,
   output logic [spr_pkg::TALLY_W-1:0]          rsp_duplicate_total,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [spr_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [spr_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [spr_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import spr_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [PRIO_W-1:0] default_priority;

   // Register 0 at byte address 0: default priority, used when an enqueue
   // transfer comes without a priority of its own.
   spr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .default_priority (default_priority)
   );

   // Sequencer: IDLE takes a request transfer once the response slot is free
   // or being drained, EXEC updates the slots and loads the response.
   spr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Sorted slots held in flops: each slot compares itself against the
   // request and picks keep, shift, or load.  Ties insert after
   // equal priorities so arrival order is kept.
   spr_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_operation),
      .req_thread_id       (req_thread_id),
      .req_priority_req    (req_priority_req),
      .req_has_priority    (req_has_priority),
      .default_priority    (default_priority),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_id         (rsp_head_id),
      .rsp_head_priority   (rsp_head_priority),
      .rsp_removed         (rsp_removed),
      .rsp_duplicate       (rsp_duplicate),
      .rsp_overflow        (rsp_overflow),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_duplicate_total (rsp_duplicate_total)
   );

endmodule
